/* sv/pbr_pkg.sv */
// Shared types and constants for the polynomial bisection root core.
// No dependencies; imported by pbr_horner, polynomial_bisection_root_core and tb.
package pbr_pkg;

  localparam int MAX_TERMS = 128;
  localparam int COEF_AW   = $clog2(MAX_TERMS);

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_EVALUATE = 2'd1,
    REQ_BISECT   = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_EVALUATED = 2'd0,
    ST_ROOT      = 2'd1,
    ST_NO_CHANGE = 2'd2,
    ST_LIMIT     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_DEGREE    = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_MAX_ITER  = 2'd2
  } cfg_reg_t;

  // coefficient write toward the store
  typedef struct packed {
    logic               en;
    logic [COEF_AW-1:0] addr;
    logic signed [31:0] data;
  } coef_wr_t;

  // evaluation result from the Horner unit
  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [31:0] value;
  } hr_res_t;

endpackage

/* sv/pbr_horner.sv */
// Horner evaluation unit: coefficient store plus one shared multiply-accumulate.
// Depends on pbr_pkg.
module pbr_horner
  import pbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  coef_wr_t           coef_wr,
  input  logic               go,
  input  logic signed [31:0] x,
  input  logic [COEF_AW-1:0] top,
  output hr_res_t            res
);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_ADD} hstate_t;

  logic signed [31:0] mem [MAX_TERMS];
  logic signed [31:0] rdata;

  hstate_t            state, state_next;
  logic [COEF_AW-1:0] j, j_next;
  logic signed [31:0] acc, acc_next;
  logic signed [31:0] x_r, x_r_next;
  logic signed [63:0] prod, prod_next;
  logic               sat, sat_next;
  logic               done, done_next;

  logic signed [63:0] sh;
  logic               sat_mul, sat_add;
  logic signed [31:0] m;
  logic signed [32:0] sum;
  logic signed [31:0] step_val;

  always_ff @(posedge clk) begin
    if (coef_wr.en) mem[coef_wr.addr] <= coef_wr.data;
    rdata <= mem[j];
  end

  // floor(acc*x / 2^16), clamp, add coefficient, clamp
  always_comb begin
    sh       = prod >>> 16;
    sat_mul  = !((&sh[63:31]) || !(|sh[63:31]));
    m        = sat_mul ? (sh[63] ? Q_MIN : Q_MAX) : sh[31:0];
    sum      = {m[31], m} + {rdata[31], rdata};
    sat_add  = sum[32] != sum[31];
    step_val = sat_add ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    acc_next   = acc;
    x_r_next   = x_r;
    prod_next  = prod;
    sat_next   = sat;
    done_next  = 1'b0;
    case (state)
      H_IDLE: begin
        if (go) begin
          acc_next   = '0;
          j_next     = top;
          x_r_next   = x;
          sat_next   = 1'b0;
          state_next = H_MUL;
        end
      end
      H_MUL: begin
        prod_next  = acc * x_r;
        state_next = H_ADD;
      end
      H_ADD: begin
        acc_next = step_val;
        sat_next = sat | sat_mul | sat_add;
        if (j == '0) begin
          done_next  = 1'b1;
          state_next = H_IDLE;
        end else begin
          j_next     = j - COEF_AW'(1);
          state_next = H_MUL;
        end
      end
      default: state_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    j    <= j_next;
    acc  <= acc_next;
    x_r  <= x_r_next;
    prod <= prod_next;
    sat  <= sat_next;
  end

  assign res.done  = done;
  assign res.sat   = sat;
  assign res.value = acc;

endmodule

/* sv/polynomial_bisection_root_core.sv */
// Polynomial bisection root core: request sequencer, config registers, output register.
// Depends on pbr_pkg and pbr_horner.
//
// One request at a time. A coefficient write leaves the core idle. An evaluate
// is worked by the single multiply-accumulate in the Horner unit, which steps
// through a multiply state and an add state for each coefficient. A bisect
// runs that evaluation for both ends, the midpoint and each further pass.
// The result sits in an output register, so the next request is taken while
// it waits. The coefficient store has no reset; a coefficient up to degree
// must be written before it is used.
module polynomial_bisection_root_core
  import pbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [6:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] point_a,
  input  logic signed [31:0] point_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [1:0]         status,
  output logic [5:0]         iterations,
  output logic               saturated
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_END_A, S_END_B, S_MID, S_PASS, S_OUT} state_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  logic [6:0]  degree;
  logic [15:0] tolerance;
  logic [5:0]  max_iterations;

  state_t             state, state_next;
  logic signed [31:0] lo, lo_next, hi, hi_next, c, c_next;
  sgn_t               sa, sa_next, sb, sb_next;
  logic [5:0]         pass, pass_next;
  logic signed [31:0] res_value, res_value_next;
  logic [1:0]         res_status, res_status_next;
  logic [5:0]         res_iters, res_iters_next;
  logic               sat_acc, sat_acc_next;
  logic               go, go_next;
  logic signed [31:0] eval_x, eval_x_next;
  logic               out_valid_next;
  logic signed [31:0] value_next;
  logic [1:0]         status_next;
  logic [5:0]         iterations_next;
  logic               saturated_next;

  coef_wr_t           coef_wr;
  hr_res_t            hres;
  logic [COEF_AW-1:0] top;
  logic               accept;
  logic [5:0]         limit;
  sgn_t               sf;
  logic [32:0]        mag;
  logic               in_tol;
  logic               sat_now;

  function automatic sgn_t sign_of(input logic signed [31:0] v);
    sgn_t s;
    s.neg = v[31];
    s.pos = !v[31] && (v != '0);
    return s;
  endfunction

  function automatic logic same_sign(input sgn_t p, input sgn_t q);
    return (p.pos && q.pos) || (p.neg && q.neg);
  endfunction

  function automatic logic opposite_sign(input sgn_t p, input sgn_t q);
    return (p.pos && q.neg) || (p.neg && q.pos);
  endfunction

  function automatic logic signed [31:0] midpoint(input logic signed [31:0] p,
                                                  input logic signed [31:0] q);
    logic signed [32:0] s;
    s = {p[31], p} + {q[31], q};
    return s[32:1];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      degree         <= 7'd0;
      tolerance      <= 16'd1;
      max_iterations <= 6'd40;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEGREE:    degree         <= cfg_data[6:0];
        CFG_TOLERANCE: tolerance      <= cfg_data;
        CFG_MAX_ITER:  max_iterations <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign top = (int'(degree) < MAX_TERMS) ? COEF_AW'(degree) : COEF_AW'(MAX_TERMS - 1);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    coef_wr.en   = accept && (req_type == REQ_WRITE) && (int'(coef_index) < MAX_TERMS);
    coef_wr.addr = COEF_AW'(coef_index);
    coef_wr.data = coef_value;
  end

  pbr_horner u_horner (
    .clk     (clk),
    .rst     (rst),
    .coef_wr (coef_wr),
    .go      (go),
    .x       (eval_x),
    .top     (top),
    .res     (hres)
  );

  assign limit   = (max_iterations == '0) ? 6'd1 : max_iterations;
  assign sf      = sign_of(hres.value);
  assign mag     = hres.value[31] ? 33'd0 - {hres.value[31], hres.value}
                                  : {1'b0, hres.value};
  assign in_tol  = mag <= {17'd0, tolerance};
  assign sat_now = sat_acc | hres.sat;

  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    c_next          = c;
    sa_next         = sa;
    sb_next         = sb;
    pass_next       = pass;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_iters_next  = res_iters;
    sat_acc_next    = sat_acc;
    go_next         = 1'b0;
    eval_x_next     = eval_x;
    out_valid_next  = out_valid && !out_ready;
    value_next      = value;
    status_next     = status;
    iterations_next = iterations;
    saturated_next  = saturated;

    case (state)
      S_IDLE: begin
        if (accept) begin
          sat_acc_next = 1'b0;
          case (req_type)
            REQ_EVALUATE: begin
              eval_x_next = point_a;
              go_next     = 1'b1;
              state_next  = S_EVAL;
            end
            REQ_BISECT: begin
              lo_next     = (point_a < point_b) ? point_a : point_b;
              hi_next     = (point_a < point_b) ? point_b : point_a;
              eval_x_next = (point_a < point_b) ? point_a : point_b;
              go_next     = 1'b1;
              state_next  = S_END_A;
            end
            default: ;
          endcase
        end
      end
      S_EVAL: begin
        if (hres.done) begin
          res_value_next  = hres.value;
          res_status_next = ST_EVALUATED;
          res_iters_next  = '0;
          sat_acc_next    = sat_now;
          state_next      = S_OUT;
        end
      end
      S_END_A: begin
        if (hres.done) begin
          sa_next      = sf;
          sat_acc_next = sat_now;
          eval_x_next  = hi;
          go_next      = 1'b1;
          state_next   = S_END_B;
        end
      end
      S_END_B: begin
        if (hres.done) begin
          sb_next      = sf;
          sat_acc_next = sat_now;
          if (same_sign(sa, sf)) begin
            res_value_next  = '0;
            res_status_next = ST_NO_CHANGE;
            res_iters_next  = '0;
            state_next      = S_OUT;
          end else begin
            c_next      = midpoint(lo, hi);
            eval_x_next = midpoint(lo, hi);
            go_next     = 1'b1;
            pass_next   = '0;
            state_next  = S_MID;
          end
        end
      end
      S_MID, S_PASS: begin
        if (hres.done) begin
          sat_acc_next = sat_now;
          if (in_tol && (state == S_MID)) begin
            // midpoint already a root
            res_value_next  = c;
            res_status_next = ST_ROOT;
            res_iters_next  = '0;
            state_next      = S_OUT;
          end else if (in_tol && (pass != limit - 6'd1)) begin
            res_value_next  = c;
            res_status_next = ST_ROOT;
            res_iters_next  = pass + 6'd1;
            state_next      = S_OUT;
          end else begin
            // first pass reuses the midpoint evaluation
            if (!same_sign(sa, sf)) begin
              hi_next = c;
              sb_next = sf;
            end else if (opposite_sign(sf, sb)) begin
              lo_next = c;
              sa_next = sf;
            end
            if (pass == limit - 6'd1) begin
              res_value_next  = c;
              res_status_next = ST_LIMIT;
              res_iters_next  = limit;
              state_next      = S_OUT;
            end else begin
              pass_next   = pass + 6'd1;
              c_next      = midpoint(lo_next, hi_next);
              eval_x_next = midpoint(lo_next, hi_next);
              go_next     = 1'b1;
              state_next  = S_PASS;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          value_next      = res_value;
          status_next     = res_status;
          iterations_next = res_iters;
          saturated_next  = sat_acc;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      go        <= go_next;
      out_valid <= out_valid_next;
    end
    lo         <= lo_next;
    hi         <= hi_next;
    c          <= c_next;
    sa         <= sa_next;
    sb         <= sb_next;
    pass       <= pass_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_iters  <= res_iters_next;
    sat_acc    <= sat_acc_next;
    eval_x     <= eval_x_next;
    value      <= value_next;
    status     <= status_next;
    iterations <= iterations_next;
    saturated  <= saturated_next;
  end

endmodule

/* test/tb.sv */
// Testbench for polynomial_bisection_root_core: a directed table, then random phases of
// coefficient writes, evaluates and bisects, each result checked against a local predictor or a known value.
// Depends on pbr_pkg and the core RTL.
module tb
  import pbr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam int                 BIG_DEGREE = 40;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
    logic [5:0]         iters;
    logic               sat;
  } root_result_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    req_t               rt;
    logic [6:0]         idx;
    logic signed [31:0] cv;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    bit                 has_known;
    root_result_t       known;
    cfg_reg_t           sel;
    int                 cfg_val;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = '0;
  logic [6:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] point_a = '0;
  logic signed [31:0] point_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic [5:0]         iterations;
  logic               saturated;

  polynomial_bisection_root_core dut (.*);

  always #1 clk = ~clk;

  // predictor state
  bit signed [31:0] coef_shadow [MAX_TERMS];
  int               cur_degree = 0;
  int               cur_tolerance = 1;
  int               cur_max_iter = 40;

  root_result_t     pending_results [$];
  root_result_t     want;
  stim_row_t        dir_plan [$];
  int               errors = 0;
  int               n_writes = 0;
  int               status_seen [4];
  bit               calm = 1'b0;
  bit               squeeze_req = 1'b0;

  function automatic longint clamp_q(longint v, inout bit sat);
    if (v > Q_MAX) begin
      sat = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < Q_MIN) begin
      sat = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  function automatic longint horner_at(longint x, inout bit sat);
    longint acc;
    int     top;
    acc = 0;
    top = (cur_degree < MAX_TERMS) ? cur_degree : MAX_TERMS - 1;
    for (int j = top; j >= 0; j--) begin
      acc = clamp_q((acc * x) >>> 16, sat);
      acc = clamp_q(acc + longint'(coef_shadow[j]), sat);
    end
    return acc;
  endfunction

  function automatic int sign_of(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic root_result_t solve_request(req_t rt, longint a, longint b);
    root_result_t r;
    bit     sat;
    longint lo, hi, c, fc, mag;
    int     sa, sb, sc, limit;
    sat = 1'b0;
    r.value = '0;
    r.status = ST_EVALUATED;
    r.iters = '0;
    if (rt == REQ_EVALUATE) begin
      r.value = 32'(horner_at(a, sat));
    end else begin
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      sa = sign_of(horner_at(lo, sat));
      sb = sign_of(horner_at(hi, sat));
      if (sa * sb > 0) begin
        r.status = ST_NO_CHANGE;
      end else begin
        limit = (cur_max_iter != 0) ? cur_max_iter : 1;
        c = (lo + hi) >>> 1;
        fc = horner_at(c, sat);
        mag = (fc < 0) ? -fc : fc;
        if (mag <= cur_tolerance) begin
          r.status = ST_ROOT;
        end else begin
          r.status = ST_LIMIT;
          r.iters = 6'(limit);
          for (int i = 0; i < limit; i++) begin
            c = (lo + hi) >>> 1;
            fc = horner_at(c, sat);
            mag = (fc < 0) ? -fc : fc;
            // the last pass never stops early
            if (mag <= cur_tolerance && i != limit - 1) begin
              r.status = ST_ROOT;
              r.iters = 6'(i + 1);
              break;
            end
            sc = sign_of(fc);
            if (sa * sc <= 0) begin
              hi = c;
              sb = sc;
            end else if (sc * sb < 0) begin
              lo = c;
              sa = sc;
            end
          end
        end
        r.value = c[31:0];
      end
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic stim_row_t req_row(req_t rt, logic [6:0] idx, logic signed [31:0] cv,
                                        logic signed [31:0] pa, logic signed [31:0] pb);
    stim_row_t r;
    r.kind = ROW_REQ;
    r.rt = rt;
    r.idx = idx;
    r.cv = cv;
    r.pa = pa;
    r.pb = pb;
    r.has_known = 1'b0;
    r.known = '0;
    r.sel = CFG_DEGREE;
    r.cfg_val = 0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(req_t rt, logic signed [31:0] pa,
                                            logic signed [31:0] pb, logic signed [31:0] v,
                                            status_t st, logic sat);
    stim_row_t r;
    r = req_row(rt, 7'h2A, 32'sh0F0F_F0F0, pa, pb);
    r.has_known = 1'b1;
    r.known = '{v, st, 6'd0, sat};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_t sel, int val);
    stim_row_t r;
    r = req_row(REQ_NONE, '0, '0, '0, '0);
    r.kind = ROW_CFG;
    r.sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic int rand_small(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] coef_pick();
    if ($urandom_range(9) == 0) return $urandom;
    return rand_small(4 * Q_ONE);
  endfunction

  task automatic send_req(req_t rt, logic [6:0] idx, logic signed [31:0] cv,
                          logic signed [31:0] pa, logic signed [31:0] pb,
                          bit has_known = 1'b0, root_result_t known = '0);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rt;
    coef_index <= idx;
    coef_value <= cv;
    point_a    <= pa;
    point_b    <= pb;
    do @(posedge clk); while (!in_ready);
    case (rt)
      REQ_WRITE: begin
        coef_shadow[idx] = cv;
        n_writes++;
      end
      REQ_EVALUATE, REQ_BISECT:
        pending_results.push_back(has_known ? known : solve_request(rt, pa, pb));
      default: ;
    endcase
  endtask

  // drain all results, then give a trailing write time to land
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, int val);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= 16'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      CFG_DEGREE:    cur_degree = val & 'h7F;
      CFG_TOLERANCE: cur_tolerance = val & 'hFFFF;
      default:       cur_max_iter = val & 'h3F;
    endcase
    @(posedge clk);
  endtask

  task automatic reconfigure(int deg, int tol, int mit);
    settle();
    write_reg(CFG_DEGREE, deg);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITER, mit);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d", value, status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, value);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (iterations !== want.iters) begin
          $error("iterations: expected %0d, got %0d", want.iters, iterations);
          errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, saturated);
          errors++;
        end
      end
    end
  end

  // receiver side; one long hold-off on request lets the core back up
  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin : main_seq
    int         deg, tol, mit, sent, roll;
    logic [6:0] idx;

    // constant polynomial, then zero, then x - 1
    dir_plan.push_back(req_row(REQ_WRITE, 7'd0, Q_MAX, '0, '0));
    dir_plan.push_back(checked_row(REQ_EVALUATE, '0, '0, Q_MAX, ST_EVALUATED, 1'b0));
    dir_plan.push_back(checked_row(REQ_BISECT, Q_MIN, Q_MAX, '0, ST_NO_CHANGE, 1'b0));
    dir_plan.push_back(req_row(REQ_NONE, 7'h7F, -32'sd1, -32'sd1, -32'sd1));
    dir_plan.push_back(req_row(REQ_WRITE, 7'h7F, Q_MIN, Q_MAX, Q_MIN));
    dir_plan.push_back(req_row(REQ_WRITE, 7'd0, '0, '0, '0));
    // zero polynomial: midpoint of the full range is already a root
    dir_plan.push_back(checked_row(REQ_BISECT, Q_MAX, Q_MIN, -32'sd1, ST_ROOT, 1'b0));
    dir_plan.push_back(req_row(REQ_WRITE, 7'd1, Q_ONE, '0, '0));
    dir_plan.push_back(req_row(REQ_WRITE, 7'd0, -Q_ONE, '0, '0));
    dir_plan.push_back(cfg_row(CFG_DEGREE, 1));
    dir_plan.push_back(checked_row(REQ_EVALUATE, 3 * Q_ONE, '0, 2 * Q_ONE, ST_EVALUATED, 1'b0));
    dir_plan.push_back(checked_row(REQ_EVALUATE, Q_MIN, '0, Q_MIN, ST_EVALUATED, 1'b1));
    // root sits on the upper end: neither end moves, runs to the pass limit
    dir_plan.push_back(req_row(REQ_BISECT, 7'd0, '0, -2 * Q_ONE, Q_ONE));
    dir_plan.push_back(req_row(REQ_BISECT, 7'd0, '0, 4 * Q_ONE, '0));
    dir_plan.push_back(checked_row(REQ_BISECT, 5 * Q_ONE, 9 * Q_ONE, '0, ST_NO_CHANGE, 1'b0));
    dir_plan.push_back(cfg_row(CFG_MAX_ITER, 0));
    dir_plan.push_back(req_row(REQ_BISECT, 7'd0, '0, '0, 3 * Q_ONE));
    dir_plan.push_back(cfg_row(CFG_MAX_ITER, 63));
    dir_plan.push_back(cfg_row(CFG_TOLERANCE, 65535));
    dir_plan.push_back(req_row(REQ_BISECT, 7'd0, '0, '0, 3 * Q_ONE));
    dir_plan.push_back(cfg_row(CFG_TOLERANCE, 0));
    dir_plan.push_back(req_row(REQ_BISECT, 7'd0, '0, '0, 3 * Q_ONE));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_plan[k]) begin
      if (dir_plan[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_plan[k].sel, dir_plan[k].cfg_val);
      end else begin
        send_req(dir_plan[k].rt, dir_plan[k].idx, dir_plan[k].cv, dir_plan[k].pa,
                 dir_plan[k].pb, dir_plan[k].has_known, dir_plan[k].known);
      end
    end

    // random phases, small degrees; fresh coefficients up to degree before each
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2);
      deg = $urandom_range(0, 4);
      for (int j = 0; j <= deg; j++)
        send_req(REQ_WRITE, 7'(j), coef_pick(), $urandom, $urandom);
      case ($urandom_range(3))
        0:       tol = 0;
        1:       tol = 65535;
        2:       tol = 1;
        default: tol = $urandom_range(2, 4000);
      endcase
      case ($urandom_range(3))
        0:       mit = 0;
        1:       mit = 63;
        2:       mit = 1;
        default: mit = $urandom_range(2, 40);
      endcase
      reconfigure(deg, tol, mit);
      if (ph == 4) squeeze_req = 1'b1;
      sent = 0;
      while (sent < 3) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          idx = $urandom_range(1) ? 7'($urandom_range(deg)) : 7'($urandom_range(127));
          send_req(REQ_WRITE, idx, coef_pick(), $urandom, $urandom);
          sent++;
        end else if (roll < 35 || ph == 4) begin
          send_req(REQ_EVALUATE, 7'($urandom), $urandom,
                   ($urandom_range(4) == 0) ? 32'($urandom) : rand_small(8 * Q_ONE),
                   $urandom);
          sent++;
        end else if (roll < 94) begin
          if ($urandom_range(6) == 0)
            send_req(REQ_BISECT, 7'($urandom), $urandom, $urandom, $urandom);
          else
            send_req(REQ_BISECT, 7'($urandom), $urandom, rand_small(8 * Q_ONE),
                     rand_small(8 * Q_ONE));
          sent++;
        end else begin
          send_req(REQ_NONE, 7'($urandom), $urandom, $urandom, $urandom);
        end
      end
    end

    // long polynomial: every coefficient up to its degree written, tiny high-order terms
    calm = 1'b0;
    for (int j = 0; j <= BIG_DEGREE; j++)
      send_req(REQ_WRITE, 7'(j), (j == 0) ? rand_small(Q_ONE) : rand_small(2048),
               $urandom, $urandom);
    reconfigure(BIG_DEGREE, 0, 63);
    send_req(REQ_EVALUATE, '0, '0, rand_small(Q_ONE), '0);
    send_req(REQ_EVALUATE, '0, '0, $urandom, '0);
    send_req(REQ_BISECT, '0, '0, -Q_ONE, Q_ONE);
    send_req(REQ_BISECT, '0, '0, $urandom, $urandom);

    settle();
    repeat (40) @(posedge clk);
    $display("covered %0d coefficient writes, %0d evaluates, degree 0 to %0d, %s",
             n_writes, status_seen[ST_EVALUATED], BIG_DEGREE, "tolerance 0 to 65535");
    $display("bisects: %0d roots, %0d without sign change, %0d at pass limit (0 to 63)",
             status_seen[ST_ROOT], status_seen[ST_NO_CHANGE], status_seen[ST_LIMIT]);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* polynomial_bisection_root_core.f */
sv/pbr_pkg.sv
sv/pbr_horner.sv
sv/polynomial_bisection_root_core.sv
test/tb.sv
